@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, off while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ rtl/core/lbfl_pkg.sv @@
// types and constants of the linked block free list allocator
package lbfl_pkg;

    localparam int LINK_W = 12;
    localparam int CNT_W  = 13;
    localparam int MAX_VOL = 4096;

    typedef enum logic [2:0] {
        FN_READ   = 3'd0,
        FN_WRITE  = 3'd1,
        FN_ALLOC  = 3'd2,
        FN_FREE   = 3'd3,
        FN_EXTEND = 3'd4,
        FN_FORMAT = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_BADCOUNT = 2'd3
    } t_status;

    localparam logic [0:0] CFG_TOTAL_BLOCKS = 1'b0;
    localparam logic [0:0] CFG_ROOT_DIR     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_RD,
        S_ALLOC_WALK,
        S_ALLOC_HEAD,
        S_ALLOC_TERM,
        S_FREE_WALK,
        S_FREE_LINK,
        S_EXT_RD,
        S_EXT_HEAD,
        S_EXT_CLR,
        S_EXT_LINK,
        S_FMT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]  total_blocks;
        logic [LINK_W-1:0] root_dir_block;
    } t_cfg;

    typedef struct packed {
        t_func             func;
        logic [LINK_W-1:0] block_index;
        logic [LINK_W-1:0] link_value;
        logic [LINK_W-1:0] block_count;
    } t_item;

    typedef struct packed {
        logic [LINK_W-1:0] result_block;
        t_status           status;
        logic [CNT_W-1:0]  free_count;
    } t_result;

endpackage

@@ rtl/core/lbfl_ram.sv @@
// link table storage: one write port, one read port, registered read data
module lbfl_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lbfl_pkg::LINK_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lbfl_pkg::LINK_W-1:0] o_rdata
);
    import lbfl_pkg::*;

    logic [LINK_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/lbfl_ctrl.sv @@
// operation sequencer: walks chains through the link table and builds results
module lbfl_ctrl #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbfl_pkg::t_cfg              i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lbfl_pkg::t_item             i_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lbfl_pkg::t_result           o_result,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [lbfl_pkg::LINK_W-1:0] o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [lbfl_pkg::LINK_W-1:0] i_mem_rdata
);
    import lbfl_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_W = CNT_W'(DEPTH);

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [LINK_W-1:0] r_blk, n_blk;
    logic [LINK_W-1:0] r_val, n_val;
    logic [LINK_W-1:0] r_cnt, n_cnt;
    logic [LINK_W-1:0] r_last, n_last;
    logic [LINK_W-1:0] r_first, n_first;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [LINK_W-1:0] r_idx, n_idx;
    logic [LINK_W-1:0] r_old, n_old;
    logic [LINK_W-1:0] r_rd, n_rd;
    logic              r_small, n_small;
    logic [LINK_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_ft, n_ft;
    logic [LINK_W-1:0] r_res, n_res;
    t_status           r_st, n_st;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [CNT_W-1:0]  w_tot;
    logic              w_blk_oor;
    logic              w_head_oor;
    logic              w_rdata_oor;
    logic              w_slot_free;
    logic [LINK_W-1:0] w_rd;
    logic [CNT_W-1:0]  w_rd_p1;
    logic [CNT_W-1:0]  w_idx_p1;
    logic [CNT_W:0]    w_sum;
    logic [LINK_W-1:0] w_fmt_val;

    assign w_tot       = (i_cfg.total_blocks > DEPTH_W) ? DEPTH_W : i_cfg.total_blocks;
    assign w_blk_oor   = {1'b0, r_blk} >= w_tot;
    assign w_head_oor  = {1'b0, r_head} >= w_tot;
    assign w_rdata_oor = {1'b0, i_mem_rdata} >= w_tot;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_rd        = (i_cfg.root_dir_block == '0) ? LINK_W'(1) : i_cfg.root_dir_block;
    assign w_rd_p1     = {1'b0, w_rd} + CNT_W'(1);
    assign w_idx_p1    = {1'b0, r_idx} + CNT_W'(1);
    assign w_sum       = {1'b0, r_ft} + {1'b0, r_n};

    // format sweep value: entry 0 the free head, reserved entries zero, free blocks chained in order
    always_comb begin
        if (r_small) begin
            w_fmt_val = '0;
        end else if (r_idx == '0) begin
            w_fmt_val = LINK_W'({1'b0, r_rd} + CNT_W'(1));
        end else if (r_idx <= r_rd) begin
            w_fmt_val = '0;
        end else if (w_idx_p1 < w_tot) begin
            w_fmt_val = w_idx_p1[LINK_W-1:0];
        end else begin
            w_fmt_val = '0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_func)
                    FN_READ:   n_state = w_blk_oor ? S_DONE : S_READ_RD;
                    FN_WRITE:  n_state = S_DONE;
                    FN_ALLOC: begin
                        if (r_cnt == '0 || r_head == '0 || w_head_oor) n_state = S_DONE;
                        else if (r_cnt == LINK_W'(1)) n_state = S_ALLOC_HEAD;
                        else n_state = S_ALLOC_WALK;
                    end
                    FN_FREE:   n_state = (r_blk == '0 || w_blk_oor) ? S_DONE : S_FREE_WALK;
                    FN_EXTEND: n_state = w_blk_oor ? S_DONE : S_EXT_RD;
                    FN_FORMAT: n_state = (w_tot == '0) ? S_DONE : S_FMT;
                    default:   n_state = S_DONE;
                endcase
            end
            S_READ_RD: n_state = S_DONE;
            S_ALLOC_WALK: begin
                if (i_mem_rdata == '0 || w_rdata_oor) n_state = S_DONE;
                else if (r_steps + LINK_W'(1) == r_cnt) n_state = S_ALLOC_HEAD;
            end
            S_ALLOC_HEAD: n_state = S_ALLOC_TERM;
            S_ALLOC_TERM: n_state = S_DONE;
            S_FREE_WALK: begin
                if (i_mem_rdata == '0) n_state = S_FREE_LINK;
                else if (w_rdata_oor || r_n >= w_tot) n_state = S_DONE;
            end
            S_FREE_LINK: n_state = S_DONE;
            S_EXT_RD: begin
                if (i_mem_rdata != '0 || r_head == '0 || w_head_oor) n_state = S_DONE;
                else n_state = S_EXT_HEAD;
            end
            S_EXT_HEAD: n_state = S_EXT_CLR;
            S_EXT_CLR:  n_state = S_EXT_LINK;
            S_EXT_LINK: n_state = S_DONE;
            S_FMT: begin
                if ({1'b0, r_idx} == w_tot - CNT_W'(1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        n_func      = r_func;
        n_blk       = r_blk;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_first     = r_first;
        n_steps     = r_steps;
        n_n         = r_n;
        n_idx       = r_idx;
        n_old       = r_old;
        n_rd        = r_rd;
        n_small     = r_small;
        n_head      = r_head;
        n_ft        = r_ft;
        n_res       = r_res;
        n_st        = r_st;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = r_blk[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_item.func;
                    n_blk  = i_item.block_index;
                    n_val  = i_item.link_value;
                    n_cnt  = i_item.block_count;
                end
            end
            S_DECODE: begin
                n_res = '0;
                n_st  = ST_OK;
                if (r_func == FN_ALLOC) o_mem_raddr = r_head[AW-1:0];
                case (r_func)
                    FN_READ: begin
                        if (w_blk_oor) n_st = ST_RANGE;
                    end
                    FN_WRITE: begin
                        if (w_blk_oor) begin
                            n_st = ST_RANGE;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_blk[AW-1:0];
                            o_mem_wdata = r_val;
                        end
                    end
                    FN_ALLOC: begin
                        if (r_cnt == '0) n_st = ST_BADCOUNT;
                        else if (r_head == '0) n_st = ST_NOSPACE;
                        else if (w_head_oor) n_st = ST_RANGE;
                        n_last  = r_head;
                        n_first = r_head;
                        n_steps = LINK_W'(1);
                    end
                    FN_FREE: begin
                        if (r_blk != '0 && w_blk_oor) n_st = ST_RANGE;
                        n_last = r_blk;
                        n_n    = CNT_W'(1);
                        n_old  = r_head;
                    end
                    FN_EXTEND: begin
                        if (w_blk_oor) n_st = ST_RANGE;
                    end
                    FN_FORMAT: begin
                        n_rd    = w_rd;
                        n_small = (w_rd_p1 >= w_tot);
                        n_idx   = '0;
                        if (w_rd_p1 >= w_tot) begin
                            n_head = '0;
                            n_ft   = '0;
                        end else begin
                            n_head = w_rd_p1[LINK_W-1:0];
                            n_ft   = w_tot - w_rd_p1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ_RD: n_res = i_mem_rdata;
            S_ALLOC_WALK: begin
                o_mem_raddr = i_mem_rdata[AW-1:0];
                if (i_mem_rdata == '0) begin
                    n_st = ST_NOSPACE;
                end else if (w_rdata_oor) begin
                    n_st = ST_RANGE;
                end else begin
                    n_last  = i_mem_rdata;
                    n_steps = r_steps + LINK_W'(1);
                end
            end
            S_ALLOC_HEAD: begin
                // entry 0 mirrors the free-list head
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = i_mem_rdata;
                n_head      = i_mem_rdata;
                n_ft        = (r_ft > {1'b0, r_cnt}) ? r_ft - {1'b0, r_cnt} : '0;
            end
            S_ALLOC_TERM: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_last[AW-1:0];
                o_mem_wdata = '0;
                n_res       = r_first;
            end
            S_FREE_WALK: begin
                o_mem_raddr = i_mem_rdata[AW-1:0];
                if (i_mem_rdata == '0) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = r_blk;
                    n_head      = r_blk;
                    n_ft        = (w_sum > {1'b0, w_tot}) ? w_tot : w_sum[CNT_W-1:0];
                end else if (w_rdata_oor || r_n >= w_tot) begin
                    // bad link or a chain that loops
                    n_st = ST_RANGE;
                end else begin
                    n_last = i_mem_rdata;
                    n_n    = r_n + CNT_W'(1);
                end
            end
            S_FREE_LINK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_last[AW-1:0];
                o_mem_wdata = r_old;
            end
            S_EXT_RD: begin
                o_mem_raddr = r_head[AW-1:0];
                if (i_mem_rdata != '0) n_res = i_mem_rdata;
                else if (r_head == '0) n_st = ST_NOSPACE;
                else if (w_head_oor) n_st = ST_RANGE;
                n_last = r_head;
            end
            S_EXT_HEAD: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = i_mem_rdata;
                n_head      = i_mem_rdata;
                n_ft        = (r_ft > '0) ? r_ft - CNT_W'(1) : '0;
            end
            S_EXT_CLR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_last[AW-1:0];
                o_mem_wdata = '0;
            end
            S_EXT_LINK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_blk[AW-1:0];
                o_mem_wdata = r_last;
                n_res       = r_last;
            end
            S_FMT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx[AW-1:0];
                o_mem_wdata = w_fmt_val;
                n_idx       = w_idx_p1[LINK_W-1:0];
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_block = r_res;
                    n_out.status       = r_st;
                    n_out.free_count   = r_ft;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_ft        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_ft        <= n_ft;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_blk   <= n_blk;
        r_val   <= n_val;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_first <= n_first;
        r_steps <= n_steps;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_old   <= n_old;
        r_rd    <= n_rd;
        r_small <= n_small;
        r_res   <= n_res;
        r_st    <= n_st;
        r_out   <= n_out;
    end

endmodule

@@ rtl/core/linked_block_free_list_allocator.sv @@
// Linked block free list allocator: FAT-style link table with a free chain.
// Input channel (s_axis): one beat is one operation; tuser carries the
// operation code, tdata the block index, link value and block count.
// Output channel (m_axis): exactly one beat per operation, in order, with the
// result block and free block count in tdata and the status in tuser.
// Configuration: plain write port, register 0 total_blocks, 1 root_dir_block;
// write only while no operation is in flight.
// Timing: with the receiver ready, the next input beat is taken at the edge of
// the output beat. Each item passes decode; write link, unused codes and decode
// errors then finish; read link registers the entry; allocate walks the chain,
// then writes the head and terminator; free walks it, then links its tail to the
// old head; extend reads, writes head, clears, links; format writes each entry.
// The single link table memory sets the pace: chain walks issue one read a
// cycle and updates one write a cycle.
// Reset clears the free head and free count and loads the register defaults;
// the link table holds nothing valid until a format or link writes.
// A stalled receiver holds the result in the output register; the next input
// beat is still taken and worked on, and waits for that register to drain.
module linked_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // block_index, link_value, block_count, zero pad
    input  logic [2:0]  i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // result_block, free_count, zero pad
    output logic [1:0]  o_m_axis_tuser   // status
);
    import lbfl_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS < MAX_VOL) ? MAX_BLOCKS : MAX_VOL;
    localparam int AW    = $clog2(DEPTH);

    t_cfg              r_cfg;
    t_item             w_item;
    t_result           w_result;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [LINK_W-1:0] w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    logic [LINK_W-1:0] w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_blocks   <= CNT_W'(MAX_VOL);
            r_cfg.root_dir_block <= LINK_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOTAL_BLOCKS: r_cfg.total_blocks   <= i_cfg_wdata;
                CFG_ROOT_DIR:     r_cfg.root_dir_block <= i_cfg_wdata[LINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_item.func        = t_func'(i_s_axis_tuser);
    assign w_item.block_index = i_s_axis_tdata[11:0];
    assign w_item.link_value  = i_s_axis_tdata[23:12];
    assign w_item.block_count = i_s_axis_tdata[35:24];

    assign o_m_axis_tdata = {7'd0, w_result.free_count, w_result.result_block};
    assign o_m_axis_tuser = w_result.status;

    lbfl_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (w_item),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    lbfl_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

@@ rtl/core/lbfl_chk.sv @@
// port-level checks of the allocator, bound to the top level
`include "assert_macros.svh"

module lbfl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import lbfl_pkg::*;

    // a stalled result beat keeps its contents
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // every error reports block 0
    `CHK_SAME(a_err_zero_block, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tdata[11:0] == 12'd0)

    // free count never exceeds the largest volume
    `CHK_SAME(a_free_bound, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[24:12] <= 13'(MAX_VOL))

    // one operation at a time: input closes right after a beat is taken
    `CHK_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

bind linked_block_free_list_allocator lbfl_chk u_chk (.*);

@@ verif/testbench.sv @@
// stream-level check of the linked block free list allocator against a table mirror
module testbench;
    import lbfl_pkg::*;

    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;
    localparam int RX_HOLD_CYCLES = 300;

    // mirror of the link table, free head and free count
    class fat_mirror;
        logic [LINK_W-1:0] links [MAX_VOL];
        int head;
        int free_left;
        int vol_reg;
        int root_reg;
        t_result due_results [$];
        int chain_heads [$];

        function new();
            head = 0;
            free_left = 0;
            vol_reg = MAX_VOL;
            root_reg = 1;
        endfunction

        function void load_reg(logic [0:0] idx, int v);
            if (idx == CFG_TOTAL_BLOCKS) vol_reg = v;
            else root_reg = v % MAX_VOL;
        endfunction

        function int vol_size();
            return (vol_reg > MAX_VOL) ? MAX_VOL : vol_reg;
        endfunction

        function int link_of(int i);
            return int'(links[i]);
        endfunction

        // entry 0 mirrors the free head whenever the head moves
        function void move_head(int h);
            head = h;
            links[0] = 12'(h);
        endfunction

        function void apply_op(t_item it);
            int vol, blk, val, cnt, res, last, nxt, steps, tail, old_head, nb, rd, k;
            bit walking, bad;
            t_status st;
            t_result r;
            vol = vol_size();
            blk = int'(it.block_index);
            val = int'(it.link_value);
            cnt = int'(it.block_count);
            res = 0;
            st = ST_OK;
            case (it.func)
                FN_READ: begin
                    if (blk >= vol) st = ST_RANGE;
                    else res = link_of(blk);
                end
                FN_WRITE: begin
                    if (blk >= vol) st = ST_RANGE;
                    else links[blk] = 12'(val);
                end
                FN_ALLOC: begin
                    last = head;
                    if (cnt == 0) st = ST_BADCOUNT;
                    else if (head == 0) st = ST_NOSPACE;
                    else if (head >= vol) st = ST_RANGE;
                    else begin
                        for (k = 1; k < cnt && st == ST_OK; k++) begin
                            last = link_of(last);
                            if (last == 0) st = ST_NOSPACE;
                            else if (last >= vol) st = ST_RANGE;
                        end
                    end
                    if (st == ST_OK) begin
                        res = head;
                        move_head(link_of(last));
                        free_left = (free_left > cnt) ? free_left - cnt : 0;
                        links[last] = '0;
                        chain_heads.push_back(res);
                        if (chain_heads.size() > 32) void'(chain_heads.pop_front());
                    end
                end
                FN_FREE: begin
                    if (blk != 0) begin
                        if (blk >= vol) st = ST_RANGE;
                        else begin
                            tail = blk;
                            steps = 1;
                            walking = 1'b1;
                            bad = 1'b0;
                            // a walk longer than the volume means a loop
                            while (walking) begin
                                nxt = link_of(tail);
                                if (nxt == 0) walking = 1'b0;
                                else if (nxt >= vol || steps >= vol) begin
                                    bad = 1'b1;
                                    walking = 1'b0;
                                end else begin
                                    tail = nxt;
                                    steps++;
                                end
                            end
                            if (bad) st = ST_RANGE;
                            else begin
                                old_head = head;
                                free_left = free_left + steps;
                                if (free_left > vol) free_left = vol;
                                move_head(blk);
                                links[tail] = 12'(old_head);
                            end
                        end
                    end
                end
                FN_EXTEND: begin
                    if (blk >= vol) st = ST_RANGE;
                    else begin
                        nxt = link_of(blk);
                        if (nxt != 0) res = nxt;
                        else begin
                            nb = head;
                            if (nb == 0) st = ST_NOSPACE;
                            else if (nb >= vol) st = ST_RANGE;
                            else begin
                                move_head(link_of(nb));
                                free_left = (free_left > 0) ? free_left - 1 : 0;
                                links[nb] = '0;
                                links[blk] = 12'(nb);
                                res = nb;
                            end
                        end
                    end
                end
                FN_FORMAT: begin
                    rd = (root_reg != 0) ? root_reg : 1;
                    chain_heads.delete();
                    if (rd + 1 >= vol) begin
                        // volume too small for any free block
                        for (k = 0; k < vol; k++) links[k] = '0;
                        head = 0;
                        free_left = 0;
                    end else begin
                        move_head(rd + 1);
                        free_left = vol - rd - 1;
                        for (k = 1; k <= rd; k++) links[k] = '0;
                        for (k = rd + 1; k + 1 < vol; k++) links[k] = 12'(k + 1);
                        links[vol - 1] = '0;
                    end
                end
                default: begin
                end
            endcase
            r.result_block = 12'(res);
            r.status = st;
            r.free_count = 13'(free_left);
            due_results.push_back(r);
        endfunction

        function bit match_result(t_result got, output string why);
            t_result want;
            why = "";
            if (due_results.size() == 0) begin
                why = $sformatf(" unexpected beat block %0d status %s free %0d",
                                got.result_block, got.status.name(), got.free_count);
                return 1'b0;
            end
            want = due_results.pop_front();
            if (got.result_block != want.result_block)
                why = {why, $sformatf(" block %0d want %0d", got.result_block,
                                      want.result_block)};
            if (got.status != want.status)
                why = {why, $sformatf(" status %s want %s", got.status.name(),
                                      want.status.name())};
            if (got.free_count != want.free_count)
                why = {why, $sformatf(" free %0d want %0d", got.free_count,
                                      want.free_count)};
            return why == "";
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_tdata = '0;   // block_index, link_value, block_count, zero pad
    logic [2:0]  s_tuser = '0;   // func
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_tdata;        // result_block, free_count, zero pad
    logic [1:0]  m_tuser;        // status

    fat_mirror fat = new();
    int mismatches = 0;
    int beats_out = 0;
    int burst_left = 0;
    bit hold_rx = 1'b0;

    linked_block_free_list_allocator #(
        .MAX_BLOCKS(MAX_VOL)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string why);
        mismatches++;
        if (mismatches <= 200) $display("mismatch at result beat %0d:%s", beats_out, why);
    endtask

    function automatic t_item make_op(t_func f, int blk, int val, int cnt);
        t_item it;
        it.func = f;
        it.block_index = 12'(blk);
        it.link_value = 12'(val);
        it.block_count = 12'(cnt);
        return it;
    endfunction

    // mostly in range, some anywhere, some block 0
    function automatic int pick_block(int vol);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k < 3) return $urandom_range(0, 4095);
        return $urandom_range(0, vol - 1);
    endfunction

    function automatic t_item random_op();
        int vol, pick, k, hi;
        t_item it;
        vol = fat.vol_size();
        hi = (vol > 4095) ? 4095 : vol;
        pick = $urandom_range(0, 99);
        it = make_op(FN_READ, pick_block(vol), $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
        if (pick < 26) begin
            it.func = FN_ALLOC;
            k = $urandom_range(0, 19);
            if (k == 0) it.block_count = '0;
            else if (k < 16) it.block_count = 12'($urandom_range(1, 6));
            else if (k < 18) it.block_count = 12'($urandom_range(1, hi));
        end else if (pick < 46) begin
            it.func = FN_FREE;
            if (fat.chain_heads.size() != 0 && $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, fat.chain_heads.size() - 1);
                it.block_index = 12'(fat.chain_heads[k]);
                fat.chain_heads.delete(k);
            end
        end else if (pick < 61) begin
            it.func = FN_EXTEND;
            if (fat.chain_heads.size() != 0 && $urandom_range(0, 1) == 1) begin
                k = $urandom_range(0, fat.chain_heads.size() - 1);
                it.block_index = 12'(fat.chain_heads[k]);
            end
        end else if (pick < 76) begin
            it.func = FN_READ;
        end else if (pick < 93) begin
            it.func = FN_WRITE;
            k = $urandom_range(0, 9);
            if (k < 7) it.link_value = 12'($urandom_range(0, vol - 1));
            else if (k < 9) it.link_value = '0;
        end else if (pick < 97) begin
            it.func = FN_FORMAT;
        end else begin
            it.func = ($urandom_range(0, 1) == 1) ? t_func'(FN_SPARE_A) : t_func'(FN_SPARE_B);
        end
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic push_op(input t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 10) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_tdata <= {4'd0, it.block_count, it.link_value, it.block_index};
        s_tuser <= it.func;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        fat.apply_op(it);
        @(negedge clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (fat.due_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input int v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= 13'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        fat.load_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic run_phase(input int vol, input int root, input int n_ops, input bit squeeze);
        drain();
        set_reg(CFG_TOTAL_BLOCKS, vol);
        set_reg(CFG_ROOT_DIR, root);
        if (squeeze) hold_rx = 1'b1;
        push_op(make_op(FN_FORMAT, 0, 0, 0));
        repeat (n_ops) push_op(random_op());
    endtask

    always @(posedge clk) begin : result_monitor
        t_result got;
        string why;
        if (rst_n && m_valid && m_ready) begin
            got.result_block = m_tdata[11:0];
            got.free_count = m_tdata[24:12];
            got.status = t_status'(m_tuser);
            beats_out++;
            if (!fat.match_result(got, why)) flag_mismatch(why);
        end
    end

    // receiver: segments of steady, random and stalled ready, plus a long hold in each squeezed phase
    initial begin : result_sink
        int len, kind;
        @(negedge clk);
        forever begin
            kind = $urandom_range(0, 3);
            len = (kind == 3) ? $urandom_range(1, 6) : $urandom_range(1, 24);
            if (hold_rx) begin
                kind = 4;
                len = RX_HOLD_CYCLES;
                hold_rx = 1'b0;
            end
            repeat (len) begin
                case (kind)
                    0, 1: m_ready <= 1'b1;
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= 1'b0;
                endcase
                @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fresh after reset, default registers: nothing read before it is written
        push_op(make_op(FN_ALLOC, 0, 0, 0));
        push_op(make_op(FN_ALLOC, 0, 0, 5));
        push_op(make_op(FN_FREE, 0, 0, 0));
        push_op(make_op(t_func'(FN_SPARE_A), 4095, 4095, 4095));
        push_op(make_op(FN_WRITE, 4095, 4095, 0));
        push_op(make_op(FN_READ, 4095, 0, 0));
        push_op(make_op(FN_EXTEND, 4095, 0, 0));
        push_op(make_op(FN_FORMAT, 0, 0, 0));
        push_op(make_op(FN_ALLOC, 0, 0, 3));
        push_op(make_op(FN_EXTEND, 4, 0, 0));
        push_op(make_op(FN_FREE, 2, 0, 0));
        push_op(make_op(FN_READ, 0, 0, 0));
        push_op(make_op(FN_ALLOC, 0, 0, 4095));
        push_op(make_op(FN_ALLOC, 0, 0, 4094));
        push_op(make_op(FN_EXTEND, 4095, 0, 0));
        push_op(make_op(FN_FREE, 2, 0, 0));

        // small volume, root 0: bad links, bad head, looping chain, count clamp
        drain();
        set_reg(CFG_TOTAL_BLOCKS, 16);
        set_reg(CFG_ROOT_DIR, 0);
        push_op(make_op(FN_FORMAT, 0, 0, 0));
        push_op(make_op(FN_READ, 16, 0, 0));
        push_op(make_op(FN_WRITE, 3, 4095, 0));
        push_op(make_op(FN_ALLOC, 0, 0, 3));
        push_op(make_op(FN_ALLOC, 0, 0, 2));
        push_op(make_op(FN_ALLOC, 0, 0, 1));
        push_op(make_op(FN_EXTEND, 15, 0, 0));
        push_op(make_op(FN_WRITE, 9, 9, 0));
        push_op(make_op(FN_FREE, 9, 0, 0));
        push_op(make_op(FN_FORMAT, 0, 0, 0));
        push_op(make_op(FN_FREE, 2, 0, 0));

        run_phase(4096, 1, 40, 1'b0);
        run_phase(2, 1, 60, 1'b0);
        run_phase(4096, 4094, 30, 1'b0);
        run_phase(16, 0, 180, 1'b0);
        run_phase(37, 5, 200, 1'b1);
        run_phase(64, 20, 200, 1'b0);
        run_phase(9, 8, 100, 1'b0);
        run_phase(128, 3, 200, 1'b1);

        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0) begin
            $display("linked_block_free_list_allocator test passed");
        end else begin
            $display("linked_block_free_list_allocator test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("linked_block_free_list_allocator test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lbfl_pkg.sv
rtl/core/lbfl_ram.sv
rtl/core/lbfl_ctrl.sv
rtl/core/linked_block_free_list_allocator.sv
rtl/core/lbfl_chk.sv
verif/testbench.sv
